// ===== src/tsrc_pkg.sv =====
// Shared constants, types and helpers of the ToF SPAD select and range check block.
package tsrc_pkg;

	localparam int DATA_W   = 16;
	localparam int STAT_W   = 8;
	localparam int DIV_W    = 24;
	localparam int RATE_SH  = 8;
	localparam int DCNT_W   = $clog2(DIV_W + 1);

	localparam logic [DATA_W-1:0] TARGET_RATE_RESET = 16'h0A00;
	localparam logic [DATA_W-1:0] SPAD_MAX          = 16'hFFFF;
	localparam logic [4:0]        STATUS_MASK       = 5'h1F;

	localparam logic [4:0] STATUS_VALID     = 5'd0;
	localparam logic [4:0] STATUS_WRAP_OK   = 5'd4;
	localparam logic [4:0] STATUS_NO_WRAP   = 5'd7;
	localparam logic [4:0] STATUS_MIN_RANGE = 5'd9;

	typedef struct packed {
		logic                  start;
		logic [DIV_W-1:0]      dividend;
		logic [DIV_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIV_W-1:0]      quotient;
	} div_rsp_t;

	function automatic logic status_ok(input logic [STAT_W-1:0] raw);
		logic [4:0] code;
		code = raw[4:0] & STATUS_MASK;
		return (code == STATUS_VALID) || (code == STATUS_WRAP_OK) ||
		       (code == STATUS_NO_WRAP) || (code == STATUS_MIN_RANGE);
	endfunction

endpackage

// ===== src/tsrc_if.sv =====
// Handshake channel interfaces: measurement input, result output and register write.
interface tsrc_meas_if
	import tsrc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              data_ready;
	logic [STAT_W-1:0] raw_status;
	logic [DATA_W-1:0] effective_spads;
	logic [DATA_W-1:0] peak_rate;
	logic [DATA_W-1:0] range_mm;

	modport source (output valid, data_ready, raw_status, effective_spads, peak_rate,
		range_mm, input ready);
	modport sink (input valid, data_ready, raw_status, effective_spads, peak_rate,
		range_mm, output ready);
endinterface

interface tsrc_res_if
	import tsrc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] held_range;
	logic              distance_valid;
	logic              spad_write;
	logic [DATA_W-1:0] spad_select;

	modport source (output valid, held_range, distance_valid, spad_write, spad_select,
		input ready);
	modport sink (input valid, held_range, distance_valid, spad_write, spad_select,
		output ready);
endinterface

interface tsrc_cfg_if
	import tsrc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== src/tof_spad_select_and_range_check.sv =====
// Top level: ToF result range check and SPAD selection update over one shared divider.
// A word is taken only in idle and handled alone: a SPAD update runs the single 24-bit
//   bit-serial divider twice, first for the rate and then, if that rate is nonzero, for
//   the selection; it is skipped when data is not ready or the SPAD count is zero.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n, asynchronous): idle, no result pending, last distance 0, target 0x0A00.
module tof_spad_select_and_range_check
	import tsrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsrc_meas_if.sink   meas,
	tsrc_res_if.source  res,
	tsrc_cfg_if.sink    cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RATE = 2'd1;
	localparam logic [1:0] ST_REQ  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [DATA_W-1:0] target_q;
	logic [DATA_W-1:0] last_dist_q;
	logic              dvalid_q;
	logic              wr_q;
	logic [DATA_W-1:0] sel_q;

	logic              res_valid_q;
	logic [DATA_W-1:0] res_dist_q;
	logic              res_dvalid_q;
	logic              res_wr_q;
	logic [DATA_W-1:0] res_sel_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     meas_acc;
	logic     range_ok;
	logic     res_free;

	tsrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign meas.ready = (state_q == ST_IDLE);
	assign meas_acc   = meas.valid && meas.ready;
	assign range_ok   = meas.data_ready && (meas.range_mm != '0) && status_ok(meas.raw_status);
	assign res_free   = !res_valid_q || res.ready;
	assign cfg.ready  = 1'b1;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {meas.peak_rate, RATE_SH'(0)};
		div_req.divisor  = {RATE_SH'(0), meas.effective_spads};
		case (state_q)
			ST_IDLE: begin
				div_req.start = meas_acc && meas.data_ready && (meas.effective_spads != '0);
			end
			ST_RATE: begin
				div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
				div_req.dividend = {target_q, RATE_SH'(0)};
				div_req.divisor  = div_rsp.quotient;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= TARGET_RATE_RESET;
			last_dist_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				target_q <= cfg.data;
			end
			// load a finished word, else drop the one just taken
			if ((state_q == ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (meas_acc) begin
						if (range_ok) begin
							last_dist_q <= meas.range_mm;
						end
						state_q <= div_req.start ? ST_RATE : ST_DONE;
					end
				end
				ST_RATE: begin
					if (div_rsp.done) begin
						state_q <= div_req.start ? ST_REQ : ST_DONE;
					end
				end
				ST_REQ: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-word result fields; saturate the selection when the quotient overflows 16 bits
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (meas_acc) begin
					dvalid_q <= range_ok;
					wr_q     <= 1'b0;
					sel_q    <= '0;
				end
			end
			ST_REQ: begin
				if (div_rsp.done) begin
					wr_q  <= 1'b1;
					sel_q <= (div_rsp.quotient[DIV_W-1:DATA_W] != '0) ? SPAD_MAX :
						div_rsp.quotient[DATA_W-1:0];
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_dist_q   <= last_dist_q;
					res_dvalid_q <= dvalid_q;
					res_wr_q     <= wr_q;
					res_sel_q    <= sel_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid          = res_valid_q;
	assign res.held_range     = res_dist_q;
	assign res.distance_valid = res_dvalid_q;
	assign res.spad_write     = res_wr_q;
	assign res.spad_select    = res_sel_q;

endmodule

// ===== src/tsrc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tsrc_div
	import tsrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_W:0]    rem_sh;
	logic              q_bit;
	logic [DIV_W:0]    rem_diff;

	always_comb begin
		rem_sh   = {rem_q, dvd_q[DIV_W-1]};
		q_bit    = (rem_sh >= {1'b0, dvs_q});
		rem_diff = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits as they are consumed
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
			rem_q <= rem_diff[DIV_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== src/tsrc_checker.sv =====
// Port-level checks on the top level, bound in below.
module tsrc_checker
	import tsrc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              meas_valid,
	input logic              meas_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [DATA_W-1:0] held_range,
	input logic              distance_valid,
	input logic              spad_write,
	input logic [DATA_W-1:0] spad_select
);

	// one word in flight: input closes straight after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
		else $error("input taken while a word is in flight");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(held_range) &&
		$stable(distance_valid) && $stable(spad_write) && $stable(spad_select))
		else $error("stalled result changed");

	a_sel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !spad_write |-> spad_select == '0)
		else $error("selection nonzero without write strobe");

	a_dist_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && distance_valid |-> held_range != '0)
		else $error("accepted distance is zero");

endmodule

bind tof_spad_select_and_range_check tsrc_checker u_tsrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.meas_valid     (meas.valid),
	.meas_ready     (meas.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.held_range     (res.held_range),
	.distance_valid (res.distance_valid),
	.spad_write     (res.spad_write),
	.spad_select    (res.spad_select)
);

// ===== verif/tof_spad_select_and_range_check_tb.sv =====
// Self-checking testbench for the ToF SPAD select and range check block.
`timescale 1ns / 100ps

module tof_spad_select_and_range_check_tb;
	import tsrc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic              data_ready;
		logic [STAT_W-1:0] raw_status;
		logic [DATA_W-1:0] effective_spads;
		logic [DATA_W-1:0] peak_rate;
		logic [DATA_W-1:0] range_mm;
	} meas_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] held_range;
		logic              distance_valid;
		logic              spad_write;
		logic [DATA_W-1:0] spad_select;
	} tof_result_t;

	// Predicts each result from the measurement words taken in and checks the outputs.
	class tof_result_tracker;
		logic [DATA_W-1:0] target_rate;
		logic [DATA_W-1:0] last_distance;
		tof_result_t       expected_results[$];
		int                mismatches;
		int                fails;
		int                reported;
		int                n_words;
		int                n_not_ready;
		int                n_accepted;
		int                n_spad_writes;
		int                n_saturated;

		function new();
			target_rate = TARGET_RATE_RESET;
			last_distance = '0;
		endfunction

		function tof_result_t predict_result(meas_word_t m);
			tof_result_t r;
			logic [4:0]  code;
			logic [31:0] rate;
			logic [31:0] need;
			r = '0;
			code = m.raw_status[4:0] & STATUS_MASK;
			if (m.data_ready) begin
				if (m.effective_spads != 0) begin
					rate = {8'd0, m.peak_rate, 8'd0} / {16'd0, m.effective_spads};
					if (rate != 0) begin
						need = {8'd0, target_rate, 8'd0} / rate;
						if (need > {16'd0, SPAD_MAX}) begin
							need = {16'd0, SPAD_MAX};
							n_saturated++;
						end
						r.spad_write = 1'b1;
						r.spad_select = need[DATA_W-1:0];
						n_spad_writes++;
					end
				end
				if (m.range_mm != 0 && (code == STATUS_VALID || code == STATUS_WRAP_OK ||
						code == STATUS_NO_WRAP || code == STATUS_MIN_RANGE)) begin
					last_distance = m.range_mm;
					r.distance_valid = 1'b1;
					n_accepted++;
				end
			end else begin
				n_not_ready++;
			end
			r.held_range = last_distance;
			return r;
		endfunction

		function void note_measurement(meas_word_t m);
			n_words++;
			expected_results.push_back(predict_result(m));
		endfunction

		function void check_result(tof_result_t got);
			tof_result_t want;
			if (expected_results.size() == 0) begin
				fails++;
				reported++;
				if (reported <= REPORT_MAX)
					$display("%0t: result with nothing pending: dist=%0d dv=%0b wr=%0b sel=%0d",
						$realtime, got.held_range, got.distance_valid, got.spad_write,
						got.spad_select);
				return;
			end
			want = expected_results.pop_front();
			if (got.held_range !== want.held_range ||
					got.distance_valid !== want.distance_valid ||
					got.spad_write !== want.spad_write ||
					got.spad_select !== want.spad_select) begin
				mismatches++;
				reported++;
				if (reported <= REPORT_MAX) begin
					$display("%0t: mismatch: expected dist=%0d dv=%0b wr=%0b sel=%0d",
						$realtime, want.held_range, want.distance_valid,
						want.spad_write, want.spad_select);
					$display("    got dist=%0d dv=%0b wr=%0b sel=%0d",
						got.held_range, got.distance_valid, got.spad_write,
						got.spad_select);
				end
			end
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_req;
	int   hold_left;

	tof_result_tracker tracker;

	tsrc_meas_if meas_ch();
	tsrc_res_if  res_ch();
	tsrc_cfg_if  cfg_ch();

	tof_spad_select_and_range_check DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				tracker.outstanding());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && meas_ch.valid && meas_ch.ready)
			tracker.note_measurement('{meas_ch.data_ready, meas_ch.raw_status,
				meas_ch.effective_spads, meas_ch.peak_rate, meas_ch.range_mm});
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.check_result('{res_ch.held_range, res_ch.distance_valid,
				res_ch.spad_write, res_ch.spad_select});
	end

	function automatic meas_word_t make_meas(logic dr, logic [STAT_W-1:0] status,
			logic [DATA_W-1:0] spads, logic [DATA_W-1:0] peak, logic [DATA_W-1:0] range_val);
		return '{dr, status, spads, peak, range_val};
	endfunction

	function automatic logic [DATA_W-1:0] random_count();
		case ($urandom_range(9))
			0:       return '0;
			1, 2, 3: return DATA_W'($urandom_range(64, 1));
			4:       return SPAD_MAX;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic meas_word_t random_measurement();
		meas_word_t m;
		logic [4:0] code;
		m.data_ready = ($urandom_range(99) < 90);
		m.raw_status = STAT_W'($urandom);
		if ($urandom_range(1)) begin
			case ($urandom_range(3))
				0: code = STATUS_VALID;
				1: code = STATUS_WRAP_OK;
				2: code = STATUS_NO_WRAP;
				default: code = STATUS_MIN_RANGE;
			endcase
			m.raw_status[4:0] = code;
		end
		m.effective_spads = random_count();
		m.peak_rate = random_count();
		m.range_mm = ($urandom_range(19) == 0) ? '0 : DATA_W'($urandom);
		return m;
	endfunction

	task automatic send_measurement(meas_word_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			meas_ch.valid <= 1'b0;
			@(posedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.data_ready <= m.data_ready;
		meas_ch.raw_status <= m.raw_status;
		meas_ch.effective_spads <= m.effective_spads;
		meas_ch.peak_rate <= m.peak_rate;
		meas_ch.range_mm <= m.range_mm;
		do @(posedge clk); while (!meas_ch.ready);
	endtask

	task automatic wait_results_drained();
		meas_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_target_rate(logic [DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		tracker.target_rate = value;
	endtask

	task automatic run_random_phase(int n_items, int idle_pct, int stall_pct, int hold_at,
			int pause_at);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at)
				wait_results_drained();
			send_measurement(random_measurement());
		end
		wait_results_drained();
	endtask

	initial begin
		tracker = new();
		cycle_count = 0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle_pct = 26;
		recv_stall_pct = 51;
		arst_n = 1'b0;
		meas_ch.valid <= 1'b0;
		meas_ch.data_ready <= 1'b0;
		meas_ch.raw_status <= '0;
		meas_ch.effective_spads <= '0;
		meas_ch.peak_rate <= '0;
		meas_ch.range_mm <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset target rate.
		send_measurement(make_meas(1'b0, 8'h00, 16'd100, 16'd100, 16'd500));
		send_measurement(make_meas(1'b1, {3'b000, STATUS_VALID}, 16'd256, 16'd256, 16'd1));
		send_measurement(make_meas(1'b1, {3'b111, STATUS_WRAP_OK}, 16'd1, 16'hFFFF, 16'hFFFF));
		send_measurement(make_meas(1'b1, {3'b101, STATUS_NO_WRAP}, 16'hFFFF, 16'hFFFF, 16'd77));
		send_measurement(make_meas(1'b1, {3'b010, STATUS_MIN_RANGE}, 16'd256, 16'd1, 16'd1234));
		send_measurement(make_meas(1'b1, 8'h01, 16'd40, 16'd900, 16'd42));
		send_measurement(make_meas(1'b1, 8'hFF, 16'd40, 16'd900, 16'd43));
		send_measurement(make_meas(1'b1, {3'b000, STATUS_VALID}, 16'd10, 16'd20, 16'd0));
		send_measurement(make_meas(1'b1, {3'b000, STATUS_VALID}, 16'd0, 16'd500, 16'd600));
		send_measurement(make_meas(1'b1, {3'b000, STATUS_WRAP_OK}, 16'd64, 16'd0, 16'd700));
		send_measurement(make_meas(1'b1, {3'b000, STATUS_VALID}, 16'hFFFF, 16'd1, 16'd800));
		send_measurement(make_meas(1'b1, 8'h1E, 16'd0, 16'd0, 16'hFFFF));
		send_measurement(make_meas(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_measurement(make_meas(1'b1, 8'h80, 16'd3, 16'd7, 16'd55));
		send_measurement(make_meas(1'b1, 8'h24, 16'd5000, 16'd30, 16'd2000));
		send_measurement(make_meas(1'b0, 8'h00, 16'd0, 16'd0, 16'd0));
		wait_results_drained();

		write_target_rate(SPAD_MAX);
		send_measurement(make_meas(1'b1, 8'h00, 16'd1, 16'hFFFF, 16'd9));
		send_measurement(make_meas(1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 16'd10));
		run_random_phase(130, 26, 51, 40, -1);

		write_target_rate('0);
		send_measurement(make_meas(1'b1, 8'h00, 16'd1, 16'd1, 16'd11));
		run_random_phase(130, 51, 26, -1, -1);

		write_target_rate(DATA_W'($urandom));
		run_random_phase(70, 0, 0, -1, 35);
		write_target_rate(16'd1);
		run_random_phase(70, 0, 0, 20, -1);

		// Write the reset value back and give the settle time before the verdict.
		write_target_rate(TARGET_RATE_RESET);
		run_random_phase(10, 0, 0, -1, -1);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tracker.outstanding() != 0) begin
			tracker.fails++;
			$display("%0d expected results never arrived", tracker.outstanding());
		end
		$display("covered %0d words: %0d not ready, %0d distances taken, %0d SPAD writes",
			tracker.n_words, tracker.n_not_ready, tracker.n_accepted, tracker.n_spad_writes);
		$display("%0d saturated selections, %0d mismatches, %0d other failures",
			tracker.n_saturated, tracker.mismatches, tracker.fails);
		if (tracker.mismatches == 0 && tracker.fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
